/* rtl/mstw_pkg.sv */
// Shared types and constants of the minimum spanning tree weight unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package mstw_pkg;

	localparam int VTX_W  = 10;   // vertex field width
	localparam int WGT_W  = 16;   // edge weight width
	localparam int SUM_W  = 32;   // tree weight width
	localparam int CNT_W  = 10;   // tree edge count width
	localparam int CFG_W  = 11;   // node_count register width
	localparam int REC_W  = 2 * VTX_W + WGT_W;

	localparam logic [WGT_W-1:0] WGT_BIAS = 16'h8000;   // signed -> unsigned order
	localparam logic REG_NODE_COUNT = 1'b0;             // register index, paddr[2]

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_SCAN,
		ST_PICK,
		ST_UNION,
		ST_HOLD
	} mst_state_t;

	typedef enum logic [2:0] {
		UF_IDLE,
		UF_CLEAR,
		UF_RD_A,
		UF_CK_A,
		UF_RD_B,
		UF_CK_B,
		UF_JOIN
	} uf_state_t;

	typedef struct packed {
		logic busy;
		logic done;     // one-cycle pulse: clear finished or join request resolved
		logic joined;   // with done: the two endpoints were in different components
	} uf_rsp_t;

endpackage

/* rtl/mstw_edge_ram.sv */
// Edge store: synchronous RAM with one write port and one registered read port.
// Depends on mstw_pkg for the record width.
`timescale 1ns / 1ps
module mstw_edge_ram
	import mstw_pkg::*;
#(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [REC_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [REC_W-1:0] rd_data
);

	logic [REC_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/mstw_uf.sv */
// Union-find engine: parent table in a synchronous RAM, clearing pass,
// root walk of both endpoints and link of the two roots. Depends on mstw_pkg.
`timescale 1ns / 1ps
module mstw_uf
	import mstw_pkg::*;
#(
	parameter int NODES = 1024,
	localparam int VW = $clog2(NODES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear_go,
	input  logic          join_go,
	input  logic [VW-1:0] vtx_a,
	input  logic [VW-1:0] vtx_b,
	output uf_rsp_t       rsp
);

	uf_state_t     state_q, state_d;
	logic [VW-1:0] cur_q, b_q, ra_q, clr_q;
	logic [VW-1:0] rd_data;
	logic [VW-1:0] wr_addr, wr_data;
	logic          wr_en, rd_en;
	logic          at_root, clr_last;

	logic [VW-1:0] parent_mem [NODES];

	assign at_root  = (rd_data == cur_q);
	assign clr_last = (clr_q == VW'(NODES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			UF_IDLE: begin
				if (clear_go) state_d = UF_CLEAR;
				else if (join_go) state_d = UF_RD_A;
			end
			UF_CLEAR: if (clr_last) state_d = UF_IDLE;
			UF_RD_A:  state_d = UF_CK_A;
			UF_CK_A:  state_d = at_root ? UF_RD_B : UF_RD_A;
			UF_RD_B:  state_d = UF_CK_B;
			UF_CK_B: begin
				if (!at_root) state_d = UF_RD_B;
				else if (cur_q == ra_q) state_d = UF_IDLE;
				else state_d = UF_JOIN;
			end
			UF_JOIN:  state_d = UF_IDLE;
			default:  state_d = UF_IDLE;
		endcase
	end

	always_comb begin
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = clr_q;
		wr_data    = clr_q;
		rsp.busy   = (state_q != UF_IDLE);
		rsp.done   = 1'b0;
		rsp.joined = 1'b0;
		case (state_q)
			UF_CLEAR: begin
				wr_en    = 1'b1;
				rsp.done = clr_last;
			end
			UF_RD_A, UF_RD_B: rd_en = 1'b1;
			UF_CK_B: rsp.done = at_root && (cur_q == ra_q);
			UF_JOIN: begin
				wr_en      = 1'b1;
				wr_addr    = ra_q;
				wr_data    = cur_q;
				rsp.done   = 1'b1;
				rsp.joined = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= UF_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			UF_IDLE: begin
				clr_q <= '0;
				cur_q <= vtx_a;
				b_q   <= vtx_b;
			end
			UF_CLEAR: clr_q <= clr_q + 1'b1;
			UF_CK_A: begin
				if (at_root) begin
					ra_q  <= cur_q;
					cur_q <= b_q;
				end else begin
					cur_q <= rd_data;
				end
			end
			UF_CK_B: if (!at_root) cur_q <= rd_data;
			default: ;
		endcase
	end

	// reads and writes never share a cycle, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			parent_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= parent_mem[cur_q];
		end
	end

endmodule

/* rtl/minimum_spanning_tree_weight_unit.sv */
// Top level of the minimum spanning tree weight unit: APB register, edge
// loading, ascending-weight scan and result register. Uses mstw_pkg,
// mstw_edge_ram and mstw_uf.
//
//  channel  signals                                       direction
//  in       in_valid/in_ready, src/dst_vertex, weight,    in
//           last_edge
//  out      out_valid/out_ready, tree_weight,             out
//           tree_edge_count, edge_overflow
//  cfg      psel/penable/pwrite/paddr/pwdata/prdata/pready APB slave
//
// Loading accepts one edge item per cycle while in_ready is high. After the
// last item the parent RAM is cleared, then each pass over the edge RAM,
// closed by a pick state, selects the next edge in weight order, followed
// for an in-range edge by a root walk in the parent RAM; there are at most
// fill+1 passes, fewer once the effective node_count less one edges are in
// the tree. Input is stalled during the run; a pending result is held until
// out_ready. Reset clears all control state; the edge RAM is not cleared.
`timescale 1ns / 1ps
module minimum_spanning_tree_weight_unit
	import mstw_pkg::*;
#(
	parameter int NODES = 1024,
	parameter int EDGES = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [VTX_W-1:0]        src_vertex,
	input  logic [VTX_W-1:0]        dst_vertex,
	input  logic signed [WGT_W-1:0] edge_weight,
	input  logic                    last_edge,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SUM_W-1:0] tree_weight,
	output logic [CNT_W-1:0]        tree_edge_count,
	output logic                    edge_overflow
);

	localparam int VW = $clog2(NODES);
	localparam int EW = $clog2(EDGES);
	localparam int FW = $clog2(EDGES + 1);
	localparam int KW = WGT_W + EW;
	localparam int NW = $clog2(NODES + 1);
	localparam int CW = (NW > CFG_W) ? NW : CFG_W;

	mst_state_t state_q, state_d;

	logic [CFG_W-1:0] node_count_q;
	logic [FW-1:0]    fill_q, scan_q;
	logic             overflow_q;
	logic             valid_s1;
	logic [EW-1:0]    idx_s1;
	logic [REC_W-1:0] rd_rec;
	logic             have_prev_q, best_valid_q;
	logic [KW-1:0]    prev_key_q, best_key_q;
	logic [VTX_W-1:0] best_src_q, best_dst_q;
	logic [WGT_W-1:0] best_w_q;
	logic [SUM_W-1:0] total_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic [SUM_W-1:0] out_weight_q;
	logic [CNT_W-1:0] out_count_q;
	logic             out_ovf_q;

	logic             in_acc, mem_wr, mem_rd, uf_clear_go, uf_join_go, out_load;
	logic [KW-1:0]    cand_key;
	logic             cand_better, in_range, tree_full;
	logic [CW-1:0]    nc_ext, limit;
	logic [CW-1:0]    src_ext, dst_ext;
	uf_rsp_t          uf_rsp;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(1024);
		end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
			node_count_q <= pwdata[CFG_W-1:0];
		end
	end

	// effective vertex limit: zero counts as one, saturate at NODES
	assign nc_ext  = CW'(node_count_q);
	assign limit   = (nc_ext == '0) ? CW'(1) :
	                 (nc_ext > CW'(NODES)) ? CW'(NODES) : nc_ext;
	assign src_ext = CW'(best_src_q);
	assign dst_ext = CW'(best_dst_q);
	assign in_range = (src_ext < limit) && (dst_ext < limit);
	// tree complete: no further edge can join two components
	assign tree_full = (CW'(count_q) == limit - CW'(1));

	// scan candidate: biased weight, then store index for stable order
	assign cand_key    = {rd_rec[REC_W-1 -: WGT_W] ^ WGT_BIAS, idx_s1};
	assign cand_better = (!have_prev_q || cand_key > prev_key_q) &&
	                     (!best_valid_q || cand_key < best_key_q);

	mstw_edge_ram #(.DEPTH(EDGES)) u_edge_ram (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (fill_q[EW-1:0]),
		.wr_data ({edge_weight, dst_vertex, src_vertex}),
		.rd_en   (mem_rd),
		.rd_addr (scan_q[EW-1:0]),
		.rd_data (rd_rec)
	);

	mstw_uf #(.NODES(NODES)) u_uf (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear_go (uf_clear_go),
		.join_go  (uf_join_go),
		.vtx_a    (src_ext[VW-1:0]),
		.vtx_b    (dst_ext[VW-1:0]),
		.rsp      (uf_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (in_valid && last_edge) state_d = ST_CLEAR;
			ST_CLEAR: if (uf_rsp.done) state_d = ST_SCAN;
			ST_SCAN:  if (scan_q == fill_q && !valid_s1) state_d = ST_PICK;
			ST_PICK: begin
				if (!best_valid_q || tree_full) state_d = ST_HOLD;
				else if (in_range) state_d = ST_UNION;
				else state_d = ST_SCAN;
			end
			ST_UNION: if (uf_rsp.done) state_d = ST_SCAN;
			ST_HOLD:  if (!out_valid_q || out_ready) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == ST_LOAD);
		in_acc      = in_ready && in_valid;
		mem_wr      = in_acc && (fill_q < FW'(EDGES));
		mem_rd      = (state_q == ST_SCAN) && (scan_q < fill_q);
		uf_clear_go = in_acc && last_edge;
		uf_join_go  = (state_q == ST_PICK) && best_valid_q && !tree_full && in_range;
		out_load    = (state_q == ST_HOLD) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			fill_q       <= '0;
			overflow_q   <= 1'b0;
			scan_q       <= '0;
			valid_s1     <= 1'b0;
			have_prev_q  <= 1'b0;
			best_valid_q <= 1'b0;
			total_q      <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= mem_rd;
			if (mem_rd) scan_q <= scan_q + 1'b1;
			if (in_acc) begin
				if (mem_wr) fill_q <= fill_q + 1'b1;
				else overflow_q <= 1'b1;
				if (last_edge) begin
					scan_q       <= '0;
					have_prev_q  <= 1'b0;
					best_valid_q <= 1'b0;
					total_q      <= '0;
					count_q      <= '0;
				end
			end
			if (valid_s1 && cand_better) best_valid_q <= 1'b1;
			if (state_q == ST_PICK) begin
				have_prev_q  <= 1'b1;
				best_valid_q <= 1'b0;
				scan_q       <= '0;
			end
			if (state_q == ST_UNION && uf_rsp.joined) begin
				total_q <= total_q + SUM_W'(signed'(best_w_q));
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				fill_q      <= '0;
				overflow_q  <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_rd) idx_s1 <= scan_q[EW-1:0];
		if (valid_s1 && cand_better) begin
			best_key_q <= cand_key;
			best_src_q <= rd_rec[VTX_W-1:0];
			best_dst_q <= rd_rec[2*VTX_W-1:VTX_W];
			best_w_q   <= rd_rec[REC_W-1 -: WGT_W];
		end
		if (state_q == ST_PICK) prev_key_q <= best_key_q;
		if (out_load) begin
			out_weight_q <= total_q;
			out_count_q  <= count_q;
			out_ovf_q    <= overflow_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign tree_weight     = out_weight_q;
	assign tree_edge_count = out_count_q;
	assign edge_overflow   = out_ovf_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(EDGES))
		else $error("edge fill count beyond store depth");

	a_uf_idle_on_go: assert property (@(posedge clk) disable iff (!arst_n)
		(uf_clear_go || uf_join_go) |-> !uf_rsp.busy)
		else $error("union-find request while engine busy");

	a_last_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_edge) |=> (state_q == ST_CLEAR))
		else $error("last edge item did not start the run");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q <= fill_q))
		else $error("scan address ran past fill count");

endmodule

/* tb/tb_minimum_spanning_tree_weight_unit.sv */
// Testbench for minimum_spanning_tree_weight_unit: sends edge lists and checks the
// tree weight, edge count and overflow flag against an in-bench Kruskal predictor.
// Depends on mstw_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_minimum_spanning_tree_weight_unit;
	import mstw_pkg::*;

	localparam int NODES = 1024;
	localparam int EDGES = 4096;

	typedef struct {
		logic [VTX_W-1:0]        src;
		logic [VTX_W-1:0]        dst;
		logic signed [WGT_W-1:0] weight;
	} edge_t;

	typedef struct {
		logic signed [SUM_W-1:0] total;
		logic [CNT_W-1:0]        count;
		logic                    overflow;
	} tree_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic [VTX_W-1:0] src_vertex = '0, dst_vertex = '0;
	logic signed [WGT_W-1:0] edge_weight = '0;
	logic last_edge = 1'b0;
	logic out_valid, out_ready = 1'b0;
	logic signed [SUM_W-1:0] tree_weight;
	logic [CNT_W-1:0] tree_edge_count;
	logic edge_overflow;

	edge_t        graph_edges[$];
	logic         graph_dropped;
	tree_result_t tree_expect_q[$];
	int           node_cfg;
	int           fail_count;
	int           edges_sent;
	int           burst_left;

	always #6 clk = ~clk;

	minimum_spanning_tree_weight_unit #(.NODES(NODES), .EDGES(EDGES)) DUT (.*);

	// Kruskal with a stable sort on signed weight and a plain union-find
	function automatic tree_result_t predict_tree();
		tree_result_t r;
		int lim, n, i, j, key, a, b, acc;
		int order[$];
		int parent[NODES];
		logic signed [SUM_W-1:0] sum;
		lim = node_cfg;
		if (lim == 0) lim = 1;
		if (lim > NODES) lim = NODES;
		n = graph_edges.size();
		for (i = 0; i < n; i++) begin
			key = i;
			order = {order, i};
			j = i;
			while (j > 0 && graph_edges[order[j-1]].weight > graph_edges[key].weight) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = key;
		end
		for (i = 0; i < NODES; i++) parent[i] = i;
		sum = 0;
		acc = 0;
		for (i = 0; i < n && acc != lim - 1; i++) begin
			a = graph_edges[order[i]].src;
			b = graph_edges[order[i]].dst;
			if (a >= lim || b >= lim) continue;
			while (parent[a] != a) a = parent[a];
			while (parent[b] != b) b = parent[b];
			if (a == b) continue;
			parent[a] = b;
			sum += SUM_W'(graph_edges[order[i]].weight);
			acc++;
		end
		r.total = sum;
		r.count = acc[CNT_W-1:0];
		r.overflow = graph_dropped;
		return r;
	endfunction

	task automatic write_node_count(input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {REG_NODE_COUNT, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		node_cfg = value[CFG_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
	endtask

	// block is idle only once every pending result is out
	task automatic drain();
		idle_input();
		while (tree_expect_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_edge(input int s, input int d, input int w, input bit last);
		edge_t e;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		src_vertex <= s[VTX_W-1:0];
		dst_vertex <= d[VTX_W-1:0];
		edge_weight <= w[WGT_W-1:0];
		last_edge <= last;
		do @(posedge clk); while (!in_ready);
		edges_sent++;
		e.src = s[VTX_W-1:0];
		e.dst = d[VTX_W-1:0];
		e.weight = w[WGT_W-1:0];
		if (graph_edges.size() < EDGES) graph_edges = {graph_edges, e};
		else graph_dropped = 1'b1;
		if (last) begin
			tree_expect_q = {tree_expect_q, predict_tree()};
			graph_edges.delete();
			graph_dropped = 1'b0;
		end
	endtask

	// random graph; most endpoints inside the configured vertex range
	task automatic send_random_graph(input int n_edges);
		int eff, s, d;
		eff = (node_cfg == 0) ? 1 : (node_cfg > NODES ? NODES : node_cfg);
		for (int i = 0; i < n_edges; i++) begin
			if ($urandom_range(0, 9) != 0) begin
				s = $urandom_range(0, eff - 1);
				d = $urandom_range(0, eff - 1);
			end else begin
				s = $urandom_range(0, NODES - 1);
				d = $urandom_range(0, NODES - 1);
			end
			send_edge(s, d, $urandom_range(0, 65535), i == n_edges - 1);
		end
	endtask

	task automatic test_reset_default();
		// node_count still at its reset value
		send_edge(0, 1023, 5, 0);
		send_edge(1023, 512, -7, 0);
		send_edge(0, 512, 100, 1);
	endtask

	task automatic test_extremes();
		drain();
		write_node_count(1024);
		send_edge(0, 1023, -32768, 0);
		send_edge(1023, 0, 32767, 0);      // parallel edge
		send_edge(5, 5, -32768, 0);         // self loop
		send_edge(682, 341, 32767, 0);
		send_edge(341, 682, -1, 1);
		send_edge(7, 7, 0, 1);              // graph of a single self loop
		send_edge(3, 4, -32768, 1);
	endtask

	task automatic test_node_count_settings();
		drain();
		write_node_count(0);                // acts as one vertex
		send_edge(0, 1, -3, 0);
		send_edge(0, 0, 2, 1);
		drain();
		write_node_count(1);
		send_edge(0, 1, 9, 1);
		drain();
		write_node_count(2);
		send_edge(2, 0, -100, 0);           // endpoint out of range
		send_edge(1, 0, 50, 0);
		send_edge(0, 1, 40, 1);
		drain();
		write_node_count(2047);             // saturates to NODES
		send_edge(1023, 1022, 11, 0);
		send_edge(1022, 0, 12, 1);
		drain();
		write_node_count(32'hFFFF_F803);    // upper bits ignored, three vertices
		send_edge(0, 1, 1, 0);
		send_edge(1, 2, 1, 0);
		send_edge(2, 0, 1, 0);
		send_edge(0, 3, -9, 1);
	endtask

	// one long graph with many weight ties over a small vertex set
	task automatic test_long_graph();
		drain();
		write_node_count(64);
		for (int i = 0; i < 256; i++)
			send_edge(i % 64, (i * 7 + 3) % 64, $urandom_range(0, 15) - 8, i == 255);
	endtask

	task automatic test_random();
		int start, n;
		logic [31:0] cfg;
		start = edges_sent;
		while (edges_sent - start < 1570) begin
			if ($urandom_range(0, 3) == 0) begin
				drain();
				case ($urandom_range(0, 9))
					0: cfg = 0;
					1: cfg = 1024;
					2: cfg = 2047;
					3: cfg = $urandom();
					4: cfg = $urandom_range(0, 2047);
					default: cfg = $urandom_range(1, 24);
				endcase
				write_node_count(cfg);
			end
			// hold off until everything is out
			if ($urandom_range(0, 15) == 0) begin
				idle_input();
				drain();
			end
			n = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 24) : $urandom_range(25, 80);
			send_random_graph(n);
		end
		idle_input();
	endtask

	// random receiver stalls, drawn against a stall percentage that ready_cycle changes
	int stall_pct = 0;
	int ready_cycle = 0;
	always @(negedge clk) begin
		ready_cycle <= ready_cycle + 1;
		if (ready_cycle % 256 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 30;
				2: stall_pct <= 70;
				default: stall_pct <= 95;
			endcase
		end
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		tree_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (tree_expect_q.size() == 0) begin
				$error("unexpected result: tree_weight %0d tree_edge_count %0d",
					tree_weight, tree_edge_count);
				fail_count++;
			end else begin
				exp_r = tree_expect_q.pop_front();
				if (tree_weight !== exp_r.total) begin
					$error("tree_weight expected %0d actual %0d", exp_r.total, tree_weight);
					fail_count++;
				end
				if (tree_edge_count !== exp_r.count) begin
					$error("tree_edge_count expected %0d actual %0d", exp_r.count,
						tree_edge_count);
					fail_count++;
				end
				if (edge_overflow !== exp_r.overflow) begin
					$error("edge_overflow expected %0b actual %0b", exp_r.overflow,
						edge_overflow);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#60ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		fail_count = 0;
		edges_sent = 0;
		burst_left = 0;
		node_cfg = 1024;
		graph_dropped = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_reset_default();
		test_extremes();
		test_node_count_settings();
		test_long_graph();
		test_random();
		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && tree_expect_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/mstw_pkg.sv
rtl/mstw_edge_ram.sv
rtl/mstw_uf.sv
rtl/minimum_spanning_tree_weight_unit.sv
tb/tb_minimum_spanning_tree_weight_unit.sv
